/* rtl/mexp_pkg.sv */
// mexp_pkg: shared widths, payload structs and sequencer states for the
// modular exponentiation block. No dependencies.
package mexp_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);

    typedef struct packed {
        logic [WIDTH-1:0] base_value;
        logic [WIDTH-1:0] exponent;
        logic [WIDTH-1:0] modulus_value;
    } mexp_in_t;

    typedef struct packed {
        logic [WIDTH-1:0] result;
        logic             error_flag;
    } mexp_out_t;

    // operands handed to the serial multiplier at start
    typedef struct packed {
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
        logic [WIDTH-1:0] m;
    } mexp_mul_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RED,
        ST_SQ,
        ST_SQ_WAIT,
        ST_MU,
        ST_MU_WAIT,
        ST_FIN
    } mexp_state_t;

endpackage

/* rtl/mexp_mulmod.sv */
// mexp_mulmod: bit-serial interleaved modular multiplier, (a * b) mod m,
// one bit of b per cycle, MSB first. Requires a < m. Uses mexp_pkg.
module mexp_mulmod
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  mexp_pkg::mexp_mul_op_t  op,
    output logic                    done,
    output logic [mexp_pkg::WIDTH-1:0] product
);

    localparam int W  = mexp_pkg::WIDTH;
    localparam int CW = mexp_pkg::CNT_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  m_reg, m_next;

    logic [W+1:0] dbl, s1, s2, s3, s4, mx, ax;
    logic [W-1:0] step;

    // acc < m and a < m, so 2*acc + a < 3m; all candidates formed in parallel
    always_comb
    begin
        mx  = {2'b00, m_reg};
        ax  = {2'b00, a_reg};
        dbl = {1'b0, acc_reg, 1'b0};
        s1  = dbl - mx;
        s2  = dbl + ax;
        s3  = dbl + ax - mx;
        s4  = s2 - {mx[W:0], 1'b0};
        if (b_reg[W-1])
        begin
            if (s2 >= {mx[W:0], 1'b0})
                step = s4[W-1:0];
            else if (s2 >= mx)
                step = s3[W-1:0];
            else
                step = s2[W-1:0];
        end
        else
        begin
            if (dbl >= mx)
                step = s1[W-1:0];
            else
                step = dbl[W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W - 1);
            acc_next  = '0;
            a_next    = op.a;
            b_next    = op.b;
            m_next    = op.m;
        end
        else if (busy_reg)
        begin
            acc_next = step;
            b_next   = {b_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* rtl/modular_exponentiation_top.sv */
// modular_exponentiation_top: square-and-multiply sequencer around the
// bit-serial multiplier, with a registered result. Uses mexp_pkg, mexp_mulmod.
//
//   channel | valid     | stall     | payload
//   request | cmd_valid | cmd_stall | cmd_data (mexp_in_t)
//   result  | rsp_valid | rsp_stall | rsp_data (mexp_out_t)
//
// Every modular product goes through the one serial multiplier.
// A request costs one base reduction plus, per exponent bit, a squaring and,
// for a set bit, a multiply.
// Zero modulus or zero exponent skips the multiplier: load goes straight to finish.
// One request in flight; a new one is taken while the last result waits.
// Asynchronous active-low reset; no clearing pass.
module modular_exponentiation_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  mexp_pkg::mexp_in_t  cmd_data,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output mexp_pkg::mexp_out_t rsp_data
);

    localparam int W  = mexp_pkg::WIDTH;
    localparam int CW = mexp_pkg::CNT_W;

    mexp_pkg::mexp_state_t state_reg, state_next;

    logic [W-1:0]  base_reg, base_next;
    logic [W-1:0]  exp_reg, exp_next;
    logic [W-1:0]  mod_reg, mod_next;
    logic [W-1:0]  r_reg, r_next;
    logic          err_reg, err_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic                rsp_valid_reg, rsp_valid_next;
    mexp_pkg::mexp_out_t rsp_data_reg, rsp_data_next;

    logic                    mul_start;
    logic                    mul_done;
    mexp_pkg::mexp_mul_op_t  mul_op;
    logic [W-1:0]            mul_product;

    logic cmd_take;
    logic mod_zero, mod_one, exp_zero, last_bit, out_free;

    assign cmd_take = cmd_valid && !cmd_stall;
    assign mod_zero = (mod_reg == '0);
    assign mod_one  = (mod_reg == W'(1));
    assign exp_zero = (exp_reg == '0);
    assign last_bit = (cnt_reg == '0);
    assign out_free = !rsp_valid_reg || !rsp_stall;

    mexp_mulmod u_mulmod
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op      (mul_op),
        .done    (mul_done),
        .product (mul_product)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mexp_pkg::ST_IDLE:
                if (cmd_take)
                    state_next = mexp_pkg::ST_LOAD;
            mexp_pkg::ST_LOAD:
                if (mod_zero || exp_zero)
                    state_next = mexp_pkg::ST_FIN;
                else
                    state_next = mexp_pkg::ST_RED;
            mexp_pkg::ST_RED:
                if (mul_done)
                    state_next = mexp_pkg::ST_SQ;
            mexp_pkg::ST_SQ:
                state_next = mexp_pkg::ST_SQ_WAIT;
            mexp_pkg::ST_SQ_WAIT:
                if (mul_done)
                begin
                    if (exp_reg[W-1])
                        state_next = mexp_pkg::ST_MU;
                    else if (last_bit)
                        state_next = mexp_pkg::ST_FIN;
                    else
                        state_next = mexp_pkg::ST_SQ;
                end
            mexp_pkg::ST_MU:
                state_next = mexp_pkg::ST_MU_WAIT;
            mexp_pkg::ST_MU_WAIT:
                if (mul_done)
                begin
                    if (last_bit)
                        state_next = mexp_pkg::ST_FIN;
                    else
                        state_next = mexp_pkg::ST_SQ;
                end
            mexp_pkg::ST_FIN:
                if (out_free)
                    state_next = mexp_pkg::ST_IDLE;
            default:
                state_next = mexp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_stall = 1'b1;
        mul_start = 1'b0;
        mul_op.m  = mod_reg;
        mul_op.a  = r_reg;
        mul_op.b  = r_reg;
        case (state_reg)
            mexp_pkg::ST_IDLE:
                cmd_stall = 1'b0;
            mexp_pkg::ST_LOAD:
            begin
                // base mod m as (1 mod m) * base
                mul_start = !mod_zero && !exp_zero;
                mul_op.a  = mod_one ? '0 : W'(1);
                mul_op.b  = base_reg;
            end
            mexp_pkg::ST_SQ:
                mul_start = 1'b1;
            mexp_pkg::ST_MU:
            begin
                mul_start = 1'b1;
                mul_op.b  = base_reg;
            end
            default:
            begin
                cmd_stall = 1'b1;
                mul_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        base_next      = base_reg;
        exp_next       = exp_reg;
        mod_next       = mod_reg;
        r_next         = r_reg;
        err_next       = err_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_data_next  = rsp_data_reg;
        if (cmd_take)
        begin
            base_next = cmd_data.base_value;
            exp_next  = cmd_data.exponent;
            mod_next  = cmd_data.modulus_value;
            cnt_next  = CW'(W - 1);
        end
        case (state_reg)
            mexp_pkg::ST_LOAD:
            begin
                err_next = mod_zero;
                if (mod_zero || (!exp_zero && mod_one))
                    r_next = '0;
                else
                    r_next = W'(1);
            end
            mexp_pkg::ST_RED:
                if (mul_done)
                    base_next = mul_product;
            mexp_pkg::ST_SQ_WAIT:
                if (mul_done)
                begin
                    r_next = mul_product;
                    if (!exp_reg[W-1])
                    begin
                        exp_next = {exp_reg[W-2:0], 1'b0};
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            mexp_pkg::ST_MU_WAIT:
                if (mul_done)
                begin
                    r_next   = mul_product;
                    exp_next = {exp_reg[W-2:0], 1'b0};
                    cnt_next = cnt_reg - 1'b1;
                end
            mexp_pkg::ST_FIN:
                if (out_free)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_data_next.result     = r_reg;
                    rsp_data_next.error_flag = err_reg;
                end
            default:
                r_next = r_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        exp_reg      <= exp_next;
        mod_reg      <= mod_next;
        r_reg        <= r_next;
        err_reg      <= err_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

`ifndef SYNTH
    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == mexp_pkg::ST_RED ||
                      state_reg == mexp_pkg::ST_SQ_WAIT ||
                      state_reg == mexp_pkg::ST_MU_WAIT))
        else $error("multiplier finished outside a wait state");

    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> state_reg == mexp_pkg::ST_LOAD)
        else $error("accepted request did not reach load");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_data_reg.error_flag) |-> rsp_data_reg.result == '0)
        else $error("error result not zero");
`endif

endmodule

/* sim/modular_exponentiation_top_test.sv */
// modular_exponentiation_top_test: self-checking bench for the modular
// exponentiation block: a directed table, then random requests under idling and back-pressure.
// Depends on mexp_pkg and modular_exponentiation_top.
module modular_exponentiation_top_test;

    localparam int W            = mexp_pkg::WIDTH;
    localparam int W2           = 2 * W;
    localparam int RANDOM_ITEMS = 270;
    localparam int QUIET_ITEMS  = 25;
    localparam int HOLD_AFTER   = 40;
    localparam int HOLD_CYCLES  = 6000;
    localparam int DRAIN_CYCLES = 2500;

    typedef struct {
        mexp_pkg::mexp_in_t  req;
        bit                  typed;
        mexp_pkg::mexp_out_t want;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_stall;
    mexp_pkg::mexp_in_t  cmd_data;
    logic                rsp_valid;
    logic                rsp_stall;
    mexp_pkg::mexp_out_t rsp_data;

    mexp_pkg::mexp_out_t pending_results[$];
    plan_row_t           plan[$];
    int                  fault_count   = 0;
    int                  accepted_reqs = 0;
    bit                  quiet         = 1'b0;

    modular_exponentiation_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // base^exponent mod modulus, exact: products of two residues fit in 2*WIDTH bits
    function automatic mexp_pkg::mexp_out_t modpow(mexp_pkg::mexp_in_t req);
        logic [W2-1:0]       m;
        logic [W2-1:0]       b;
        logic [W2-1:0]       acc;
        mexp_pkg::mexp_out_t r;
        r = '0;
        if (req.modulus_value == '0)
        begin
            r.error_flag = 1'b1;
            return r;
        end
        if (req.exponent == '0)
        begin
            r.result = W'(1);
            return r;
        end
        m   = W2'(req.modulus_value);
        b   = W2'(req.base_value) % m;
        acc = W2'(1) % m;
        for (int i = W - 1; i >= 0; i--)
        begin
            acc = (acc * acc) % m;
            if (req.exponent[i])
                acc = (acc * b) % m;
        end
        r.result = acc[W-1:0];
        return r;
    endfunction

    function automatic plan_row_t row(logic [W-1:0] b, logic [W-1:0] e,
                                      logic [W-1:0] m, bit typed,
                                      logic [W-1:0] res, logic err);
        plan_row_t p;
        p.req.base_value    = b;
        p.req.exponent      = e;
        p.req.modulus_value = m;
        p.typed             = typed;
        p.want.result       = res;
        p.want.error_flag   = err;
        return p;
    endfunction

    function automatic mexp_pkg::mexp_in_t draw_request();
        mexp_pkg::mexp_in_t req;
        int                 kind;
        kind              = $urandom_range(0, 19);
        req.base_value    = $urandom;
        req.exponent      = $urandom;
        req.modulus_value = $urandom;
        case (kind)
            0:       req.modulus_value = '0;
            1:       req.exponent = '0;
            2:       req.modulus_value = W'(1);
            3, 4, 5: req.modulus_value = $urandom_range(2, 16);
            6:       req.modulus_value = $urandom | {1'b1, {(W-1){1'b0}}};
            7:       req.exponent = $urandom_range(1, 8);
            8:       req.base_value = $urandom_range(0, 3);
            default: ;
        endcase
        return req;
    endfunction

    function automatic void note_fault(string what);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch: %s", what);
    endfunction

    task automatic issue_request(mexp_pkg::mexp_in_t req, mexp_pkg::mexp_out_t want);
        cmd_valid <= 1'b1;
        cmd_data  <= req;
        do
            @(posedge clk);
        while (cmd_stall);
        pending_results.push_back(want);
        accepted_reqs++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        mexp_pkg::mexp_out_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
                note_fault($sformatf("unexpected result %h err %b",
                                     rsp_data.result, rsp_data.error_flag));
            else
            begin
                want = pending_results.pop_front();
                if (rsp_data.result !== want.result)
                    note_fault($sformatf("result exp %h got %h",
                                         want.result, rsp_data.result));
                if (rsp_data.error_flag !== want.error_flag)
                    note_fault($sformatf("error_flag exp %b got %b",
                                         want.error_flag, rsp_data.error_flag));
            end
        end
    end

    // result side: random stall bursts, one long hold to back the block up
    initial
    begin
        bit held;
        held = 1'b0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && accepted_reqs >= HOLD_AFTER)
            begin
                held = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #(20 * 4_000_000);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        mexp_pkg::mexp_in_t  req;
        mexp_pkg::mexp_out_t want;
        int                  total;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd_data  <= '0;

        // zero modulus wins over everything
        plan.push_back(row(32'h0,         32'h0,         32'h0,         1, 32'h0,  1'b1));
        plan.push_back(row(32'hffff_ffff, 32'hffff_ffff, 32'h0,         1, 32'h0,  1'b1));
        plan.push_back(row(32'h5,         32'h0,         32'h0,         1, 32'h0,  1'b1));
        // zero exponent: 1 without reduction
        plan.push_back(row(32'h5,         32'h0,         32'h7,         1, 32'h1,  1'b0));
        plan.push_back(row(32'h5,         32'h0,         32'h1,         1, 32'h1,  1'b0));
        plan.push_back(row(32'hffff_ffff, 32'h0,         32'hffff_ffff, 1, 32'h1,  1'b0));
        plan.push_back(row(32'h0,         32'h0,         32'h5,         1, 32'h1,  1'b0));
        // modulus of one
        plan.push_back(row(32'h123,       32'h1,         32'h1,         1, 32'h0,  1'b0));
        plan.push_back(row(32'hffff_ffff, 32'hffff_ffff, 32'h1,         1, 32'h0,  1'b0));
        // base above modulus is reduced first, then general cases; untyped rows use modpow
        plan.push_back(row(32'ha,         32'h1,         32'h7,         1, 32'h3,  1'b0));
        plan.push_back(row(32'hffff_ffff, 32'h1,         32'hffff_ffff, 1, 32'h0,  1'b0));
        plan.push_back(row(32'hffff_ffff, 32'h2,         32'hffff_fffe, 1, 32'h1,  1'b0));
        plan.push_back(row(32'h0,         32'h1,         32'hd,         1, 32'h0,  1'b0));
        plan.push_back(row(32'h2,         32'ha,         32'd1000,      1, 32'd24, 1'b0));
        plan.push_back(row(32'h3,         32'h4,         32'd100,       1, 32'd81, 1'b0));
        plan.push_back(row(32'h1,         32'hffff_ffff, 32'h2,         1, 32'h1,  1'b0));
        plan.push_back(row(32'h0,         32'hffff_ffff, 32'hffff_ffff, 0, 32'h0,  1'b0));
        plan.push_back(row(32'hffff_fffe, 32'hffff_ffff, 32'hffff_ffff, 0, 32'h0,  1'b0));
        plan.push_back(row(32'h1234_5678, 32'h8765_4321, 32'hffff_fffb, 0, 32'h0,  1'b0));
        plan.push_back(row(32'h7,         32'h8000_0000, 32'h8000_0000, 0, 32'h0,  1'b0));
        plan.push_back(row(32'hffff_ffff, 32'hffff_ffff, 32'hffff_fffb, 0, 32'h0,  1'b0));
        plan.push_back(row(32'h8000_0001, 32'h5555_5555, 32'haaaa_aaab, 0, 32'h0,  1'b0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        total = plan.size() + RANDOM_ITEMS;
        for (int idx = 0; idx < total; idx++)
        begin
            quiet = (idx >= total - QUIET_ITEMS);
            if (idx < plan.size())
            begin
                req  = plan[idx].req;
                want = plan[idx].typed ? plan[idx].want : modpow(req);
            end
            else
            begin
                req  = draw_request();
                want = modpow(req);
            end
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                cmd_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            issue_request(req, want);
        end
        cmd_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/mexp_pkg.sv
rtl/mexp_mulmod.sv
rtl/modular_exponentiation_top.sv
sim/modular_exponentiation_top_test.sv
